@@ sv/frc_pkg.sv @@
// ----------------------------------------------------------------------------
// frc_pkg: shared definitions for the flag delimited frame receiver
// Framing constants, result codes, the result record and the CRC-32 byte step.
// ----------------------------------------------------------------------------
package frc_pkg;

   // Framing constants
   localparam logic [7:0]  FlagByte   = 8'h7e;
   localparam logic [31:0] CrcPoly    = 32'hEDB88320;
   localparam logic [31:0] CrcOnes    = 32'hFFFFFFFF;
   localparam int          HeaderLen  = 12;
   localparam int          TrailerLen = 4;
   localparam int          MinFrame   = HeaderLen + TrailerLen;

   // Byte position within a frame saturates once the header is behind us
   localparam int PosW = $clog2(MinFrame + 1);
   localparam int HdrW = $clog2(HeaderLen);

   // Header byte offsets
   localparam logic [HdrW-1:0] HdrMsgId  = HdrW'(0);
   localparam logic [HdrW-1:0] HdrSubId  = HdrW'(1);
   localparam logic [HdrW-1:0] HdrErrFlg = HdrW'(3);
   localparam logic [HdrW-1:0] HdrConnLo = HdrW'(4);
   localparam logic [HdrW-1:0] HdrConnHi = HdrW'(5);
   localparam logic [HdrW-1:0] HdrSize0  = HdrW'(8);
   localparam logic [HdrW-1:0] HdrSize1  = HdrW'(9);
   localparam logic [HdrW-1:0] HdrSize2  = HdrW'(10);
   localparam logic [HdrW-1:0] HdrSize3  = HdrW'(11);

   typedef enum logic {
      KIND_PAYLOAD = 1'b0,
      KIND_SUMMARY = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_CRC_ERR = 2'd1,
      STATUS_SHORT   = 2'd2
   } status_type;

   // One result item
   typedef struct packed {
      kind_type    kind;
      logic [7:0]  payload_byte;
      status_type  status;
      logic [15:0] command_word;
      logic        device_error;
      logic [15:0] learned_conn_id;
      logic [31:0] payload_length;
   } result_type;

   // Reflected CRC-32 update by one byte, bit at a time
   function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = {24'b0, crc[7:0] ^ b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? (CrcPoly ^ (c >> 1)) : (c >> 1);
      end
      return c ^ (crc >> 8);
   endfunction

endpackage

@@ sv/frc_parser.sv @@
// ----------------------------------------------------------------------------
// frc_parser: frame state and per-byte decode
// Holds the trailer delay line, CRC and header fields, and forms at most one
// result for each byte transferred in.
// ----------------------------------------------------------------------------
module frc_parser
   import frc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        byte_accept,
   input  logic [7:0]  rx_byte,
   output logic        res_valid,
   output result_type  res
);

   logic                  in_frame_ff, in_frame_in;
   logic [PosW-1:0]       pos_ff, pos_in;
   logic [7:0]            delay_ff [TrailerLen];
   logic [7:0]            delay_in [TrailerLen];
   logic [31:0]           crc_ff, crc_in;
   logic [15:0]           cmd_ff, cmd_in;
   logic [7:0]            err_ff, err_in;
   logic [15:0]           conn_ff, conn_in;
   logic [31:0]           size_ff, size_in;
   logic [15:0]           store_ff, store_in;
   logic [31:0]           count_ff, count_in;

   logic                  is_flag;
   logic [HdrW-1:0]       hdr_idx;
   logic [31:0]           want_crc;
   logic                  crc_ok;
   logic                  short_frame;
   logic [7:0]            old_byte;

   assign is_flag     = (rx_byte == FlagByte);
   assign old_byte    = delay_ff[0];
   assign hdr_idx     = HdrW'(pos_ff - PosW'(TrailerLen));
   assign want_crc    = {delay_ff[3], delay_ff[2], delay_ff[1], delay_ff[0]};
   assign crc_ok      = ((crc_ff ^ CrcOnes) == want_crc);
   assign short_frame = (pos_ff < PosW'(MinFrame));

   // Next state and result for the byte on the input
   always_comb begin
      in_frame_in = in_frame_ff;
      pos_in      = pos_ff;
      delay_in    = delay_ff;
      crc_in      = crc_ff;
      cmd_in      = cmd_ff;
      err_in      = err_ff;
      conn_in     = conn_ff;
      size_in     = size_ff;
      store_in    = store_ff;
      count_in    = count_ff;
      res_valid   = 1'b0;
      res         = '0;

      if (byte_accept && is_flag) begin
         // A flag closes the current frame and opens the next one.
         if (in_frame_ff && (pos_ff != '0)) begin
            res_valid = 1'b1;
            res.kind  = KIND_SUMMARY;
            if (short_frame) begin
               res.status = STATUS_SHORT;
            end else begin
               res.status = crc_ok ? STATUS_OK : STATUS_CRC_ERR;
               if (crc_ok && (store_ff == '0) && (conn_ff != '0)) begin
                  store_in = conn_ff;
               end
               res.command_word   = cmd_ff;
               res.device_error   = (err_ff != '0);
               res.payload_length = count_ff;
            end
            res.learned_conn_id = store_in;
         end
         in_frame_in = 1'b1;
         pos_in      = '0;
         crc_in      = CrcOnes;
         count_in    = '0;
      end else if (byte_accept && in_frame_ff) begin
         // The oldest delayed byte is content once four bytes are held.
         if (pos_ff >= PosW'(TrailerLen)) begin
            crc_in = crc32_byte(crc_ff, old_byte);
            if (short_frame) begin
               unique case (hdr_idx)
                  HdrMsgId:  cmd_in[15:8]   = old_byte;
                  HdrSubId:  cmd_in[7:0]    = old_byte;
                  HdrErrFlg: err_in         = old_byte;
                  HdrConnLo: conn_in[7:0]   = old_byte;
                  HdrConnHi: conn_in[15:8]  = old_byte;
                  HdrSize0:  size_in[7:0]   = old_byte;
                  HdrSize1:  size_in[15:8]  = old_byte;
                  HdrSize2:  size_in[23:16] = old_byte;
                  HdrSize3:  size_in[31:24] = old_byte;
                  default: ;
               endcase
            end else if (count_ff < size_ff) begin
               count_in         = count_ff + 32'd1;
               res_valid        = 1'b1;
               res.kind         = KIND_PAYLOAD;
               res.payload_byte = old_byte;
            end
         end
         for (int i = 0; i < TrailerLen - 1; i++) begin
            delay_in[i] = delay_ff[i+1];
         end
         delay_in[TrailerLen-1] = rx_byte;
         if (pos_ff != PosW'(MinFrame)) begin
            pos_in = pos_ff + PosW'(1);
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         pos_ff      <= '0;
         crc_ff      <= CrcOnes;
         store_ff    <= '0;
         count_ff    <= '0;
      end else begin
         in_frame_ff <= in_frame_in;
         pos_ff      <= pos_in;
         crc_ff      <= crc_in;
         store_ff    <= store_in;
         count_ff    <= count_in;
      end
   end

   // Delay line and header fields
   always_ff @(posedge clock) begin
      delay_ff <= delay_in;
      cmd_ff   <= cmd_in;
      err_ff   <= err_in;
      conn_ff  <= conn_in;
      size_ff  <= size_in;
   end

endmodule

@@ sv/frc_out_buf.sv @@
// ----------------------------------------------------------------------------
// frc_out_buf: result register with skid stage
// Registers each result and catches one more while the output is stalled.
// ----------------------------------------------------------------------------
module frc_out_buf
   import frc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  result_type  in_data,
   output logic        full,
   output logic        out_valid,
   input  logic        out_stall,
   output result_type  out_data
);

   logic        out_valid_ff, out_valid_in;
   logic        skid_valid_ff, skid_valid_in;
   result_type  out_data_ff, out_data_in;
   result_type  skid_data_ff, skid_data_in;
   logic        take;

   assign take      = out_valid_ff && !out_stall;
   assign full      = skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

   // Buffer control
   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      priority if (skid_valid_ff) begin
         if (take) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (in_valid) begin
         if (!out_valid_ff || take) begin
            out_data_in  = in_data;
            out_valid_in = 1'b1;
         end else begin
            skid_data_in  = in_data;
            skid_valid_in = 1'b1;
         end
      end else if (take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

`ifndef NO_ASSERTIONS
   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid stage holds a result while the output register is empty");

   a_no_write_when_full: assert property (@(posedge clock) disable iff (reset)
      !(in_valid && skid_valid_ff))
      else $error("result arrived while the skid stage was full");

   a_stall_fills_skid: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_stall && in_valid) |=> skid_valid_ff)
      else $error("result lost while the output was stalled");
`endif

endmodule

@@ sv/flag_delimited_frame_receiver_crc32.sv @@
// ----------------------------------------------------------------------------
// flag_delimited_frame_receiver_crc32: framed byte receiver with CRC-32 check
// Splits a flag delimited byte stream into frames, streams payload bytes and
// reports one end-of-frame summary per non-empty frame.
// ----------------------------------------------------------------------------
// Each result is registered in the output buffer before it shows on rsp_.
// Throughput: one byte per cycle unless req_stall is high; the CRC byte step
// and the delay line shift both complete in the cycle the byte is transferred.
// req_stall rises only while the two-entry result buffer is full.
// Reset (synchronous, active high) drops any partial frame, clears the learned
// connection id and waits for a flag byte before a frame opens.
module flag_delimited_frame_receiver_crc32
   import frc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_result_kind,
   output logic [7:0]  rsp_payload_byte,
   output logic [1:0]  rsp_frame_status,
   output logic [15:0] rsp_command_word,
   output logic        rsp_device_error,
   output logic [15:0] rsp_learned_conn_id,
   output logic [31:0] rsp_payload_length
);

   logic        byte_accept;
   logic        res_valid;
   result_type  res;
   result_type  rsp_data;

   // A byte is transferred when valid and not stalled.
   assign byte_accept = req_valid && !req_stall;

   frc_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .byte_accept (byte_accept),
      .rx_byte     (req_rx_byte),
      .res_valid   (res_valid),
      .res         (res)
   );

   frc_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (res_valid),
      .in_data   (res),
      .full      (req_stall),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (rsp_data)
   );

   // Result fields onto their own ports
   assign rsp_result_kind     = rsp_data.kind;
   assign rsp_payload_byte    = rsp_data.payload_byte;
   assign rsp_frame_status    = rsp_data.status;
   assign rsp_command_word    = rsp_data.command_word;
   assign rsp_device_error    = rsp_data.device_error;
   assign rsp_learned_conn_id = rsp_data.learned_conn_id;
   assign rsp_payload_length  = rsp_data.payload_length;

endmodule
